### rtl/scab_pkg.sv
// ----------------------------------------------------------------------------
// scab_pkg: shared types and constants for the shape coverage alpha blend
// Request/response payload structs, register indexes, shape mode codes and
// the fixed widths of the coverage datapath.
// ----------------------------------------------------------------------------
package scab_pkg;

   // coordinate width for corners, spans and offsets (covers -16384..16383)
   localparam int COORD_W = 15;
   // width of squared distances and circle thresholds
   localparam int DIST_W  = 25;
   // color channel width
   localparam int CHAN_W  = 8;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_TRANSPARENT = 8'h00;

   // register indexes on the csr port
   localparam logic [2:0] CSR_SHAPE_MODE       = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_X         = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Y         = 3'd2;
   localparam logic [2:0] CSR_SIZE_W           = 3'd3;
   localparam logic [2:0] CSR_SIZE_H           = 3'd4;
   localparam logic [2:0] CSR_CIRCLE_RADIUS    = 3'd5;
   localparam logic [2:0] CSR_STROKE_THICKNESS = 3'd6;
   localparam logic [2:0] CSR_DRAW_COLOR       = 3'd7;

   // shape modes
   localparam logic [1:0] MODE_FILL_RECT   = 2'd0;
   localparam logic [1:0] MODE_RECT_LINE   = 2'd1;
   localparam logic [1:0] MODE_FILL_CIRCLE = 2'd2;
   localparam logic [1:0] MODE_CIRCLE_RING = 2'd3;

   typedef struct packed {
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [31:0] dest_pixel;
   } req_type;

   typedef struct packed {
      logic        covered;
      logic [31:0] result_pixel;
   } rsp_type;

endpackage

### rtl/scab_blend.sv
// ----------------------------------------------------------------------------
// scab_blend: source-over blend of the draw color onto a pixel
// One register stage holds the per-channel products; the sum, the divide by
// 255 and the opaque/transparent shortcuts follow combinationally.
// ----------------------------------------------------------------------------
module scab_blend (
   input  logic        clock,
   input  logic        load_en,
   input  logic [31:0] src_color,
   input  logic [31:0] dst_color,
   output logic [31:0] blended
);

   localparam int CW   = scab_pkg::CHAN_W;
   localparam int PW   = 2 * CW;
   localparam int NCH  = 3;

   logic [PW-1:0] prod_s_ff [NCH];
   logic [PW-1:0] prod_d_ff [NCH];
   logic [PW-1:0] prod_s_in [NCH];
   logic [PW-1:0] prod_d_in [NCH];
   logic          opaque_ff, opaque_in;
   logic          clear_ff, clear_in;
   logic [31:0]   src_ff;
   logic [31:0]   dst_ff;
   logic [CW-1:0] chan_out [NCH];

   // channel products: s*a and d*(255-a)
   always_comb begin
      logic [CW-1:0] alpha;
      logic [CW-1:0] inv_alpha;
      alpha     = src_color[3*CW +: CW];
      inv_alpha = scab_pkg::ALPHA_OPAQUE - alpha;
      opaque_in = (alpha == scab_pkg::ALPHA_OPAQUE);
      clear_in  = (alpha == scab_pkg::ALPHA_TRANSPARENT);
      for (int i = 0; i < NCH; i++) begin
         prod_s_in[i] = PW'(src_color[i*CW +: CW]) * PW'(alpha);
         prod_d_in[i] = PW'(dst_color[i*CW +: CW]) * PW'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         opaque_ff <= opaque_in;
         clear_ff  <= clear_in;
         src_ff    <= src_color;
         dst_ff    <= dst_color;
         for (int i = 0; i < NCH; i++) begin
            prod_s_ff[i] <= prod_s_in[i];
            prod_d_ff[i] <= prod_d_in[i];
         end
      end
   end

   // sum and truncating divide by 255: (x + (x >> 8) + 1) >> 8, exact below 65535
   always_comb begin
      logic [PW:0] sum;
      logic [PW:0] quot;
      for (int i = 0; i < NCH; i++) begin
         sum         = (PW+1)'(prod_s_ff[i]) + (PW+1)'(prod_d_ff[i]);
         quot        = (sum + (sum >> CW) + (PW+1)'(1)) >> CW;
         chan_out[i] = quot[CW-1:0];
      end
   end

   // shortcuts, then forced-opaque result
   always_comb begin
      if (opaque_ff) begin
         blended = src_ff;
      end else if (clear_ff) begin
         blended = dst_ff;
      end else begin
         blended = {scab_pkg::ALPHA_OPAQUE, chan_out[2], chan_out[1], chan_out[0]};
      end
   end

endmodule

### rtl/shape_coverage_alpha_blend.sv
// ----------------------------------------------------------------------------
// shape_coverage_alpha_blend: per-pixel shape coverage and alpha blend
// Decides whether the configured rectangle, outline, disc or ring covers a
// framebuffer pixel and returns the draw color blended over it.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry one pixel (x, y, current value) on req_valid/req_data and
//   are taken at an edge where req_valid is high and req_stall is low.
//   Responses (covered flag, new pixel value) leave on rsp_valid/rsp_data in
//   request order, taken when rsp_stall is low.
//   Registers are written through csr_write_en/csr_index/csr_wdata while the
//   pipeline is empty; a few derived thresholds are registered from the
//   registers (inner_ff behind k_ff) and are consumed only from the second stage on.
//   Five register stages, s1 to s5: a request taken into s1 passes through
//   each in order and is presented on the response side from s5. One pixel
//   per cycle is accepted while req_stall is low, with the coordinate
//   squares and the blend products each in a stage of their own.
//   When the receiver stalls, each stage holds its data and empty stages
//   still fill; req_stall rises only once every stage is occupied.
//   Synchronous reset empties the pipeline and loads register defaults
//   (filled rectangle at the origin of size zero, thickness 1, color 0).
// ----------------------------------------------------------------------------
module shape_coverage_alpha_blend #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  scab_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scab_pkg::rsp_type rsp_data,
   // register write port
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int CW = scab_pkg::COORD_W;
   localparam int DW = scab_pkg::DIST_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [1:0]         mode_ff;
   logic signed [11:0] origin_x_ff;
   logic signed [11:0] origin_y_ff;
   logic signed [11:0] size_w_ff;
   logic signed [11:0] size_h_ff;
   logic [10:0]        radius_ff;
   logic signed [11:0] thick_ff;
   logic [31:0]        color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= scab_pkg::MODE_FILL_RECT;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         size_w_ff   <= '0;
         size_h_ff   <= '0;
         radius_ff   <= '0;
         thick_ff    <= 12'sd1;
         color_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            scab_pkg::CSR_SHAPE_MODE:       mode_ff     <= csr_wdata[1:0];
            scab_pkg::CSR_ORIGIN_X:         origin_x_ff <= csr_wdata[11:0];
            scab_pkg::CSR_ORIGIN_Y:         origin_y_ff <= csr_wdata[11:0];
            scab_pkg::CSR_SIZE_W:           size_w_ff   <= csr_wdata[11:0];
            scab_pkg::CSR_SIZE_H:           size_h_ff   <= csr_wdata[11:0];
            scab_pkg::CSR_CIRCLE_RADIUS:    radius_ff   <= csr_wdata[10:0];
            scab_pkg::CSR_STROKE_THICKNESS: thick_ff    <= csr_wdata[11:0];
            scab_pkg::CSR_DRAW_COLOR:       color_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // derived shape bounds, refreshed every cycle from the registers
   // ------------------------------------------------------------------
   logic signed [CW-1:0] ox_s, oy_s, w_s, h_s, t_s;
   logic signed [CW-1:0] x_lo_ff, x_hi_ff, xi_lo_ff, xi_hi_ff;
   logic signed [CW-1:0] y_lo_ff, y_hi_ff, yi_lo_ff, yi_hi_ff;
   logic signed [CW-1:0] x_lo_in, x_hi_in, xi_lo_in, xi_hi_in;
   logic signed [CW-1:0] y_lo_in, y_hi_in, yi_lo_in, yi_hi_in;
   logic signed [CW-1:0] k_ff, k_in;
   logic [DW-1:0]        outer_ff, outer_in;
   logic [DW-1:0]        inner_ff, inner_in;
   logic [21:0]          r_sq;
   logic signed [2*CW-1:0] k_sq;

   assign ox_s = CW'(origin_x_ff);
   assign oy_s = CW'(origin_y_ff);
   assign w_s  = CW'(size_w_ff);
   assign h_s  = CW'(size_h_ff);
   assign t_s  = CW'(thick_ff);

   // normalized outer span [lo, hi) and inner span [lo + t, hi - t)
   always_comb begin
      logic signed [CW-1:0] w_lo, w_hi, h_lo, h_hi;
      w_lo = size_w_ff[11] ? w_s : '0;
      w_hi = size_w_ff[11] ? '0 : w_s;
      h_lo = size_h_ff[11] ? h_s : '0;
      h_hi = size_h_ff[11] ? '0 : h_s;
      x_lo_in  = ox_s + w_lo;
      x_hi_in  = ox_s + w_hi;
      xi_lo_in = ox_s + w_lo + t_s;
      xi_hi_in = ox_s + w_hi - t_s;
      y_lo_in  = oy_s + h_lo;
      y_hi_in  = oy_s + h_hi;
      yi_lo_in = oy_s + h_lo + t_s;
      yi_hi_in = oy_s + h_hi - t_s;
   end

   // circle thresholds: outer r*r + r, inner (r - t)^2 + r
   assign r_sq     = radius_ff * radius_ff;
   assign outer_in = DW'(r_sq) + DW'(radius_ff);
   assign k_in     = CW'(signed'({1'b0, radius_ff})) - t_s;
   assign k_sq     = k_ff * k_ff;
   assign inner_in = k_sq[DW-1:0] + DW'(radius_ff);

   always_ff @(posedge clock) begin
      x_lo_ff  <= x_lo_in;
      x_hi_ff  <= x_hi_in;
      xi_lo_ff <= xi_lo_in;
      xi_hi_ff <= xi_hi_in;
      y_lo_ff  <= y_lo_in;
      y_hi_ff  <= y_hi_in;
      yi_lo_ff <= yi_lo_in;
      yi_hi_ff <= yi_hi_in;
      outer_ff <= outer_in;
      k_ff     <= k_in;
      inner_ff <= inner_in;
   end

   // ------------------------------------------------------------------
   // stage enables: a stage loads when it is empty or its successor loads
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5       = !s5_valid_ff || !rsp_stall;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: frame clip, center offsets
   // ------------------------------------------------------------------
   logic [9:0]           s1_px_ff, s1_py_ff;
   logic [31:0]          s1_dest_ff;
   logic                 s1_in_frame_ff, s1_in_frame_in;
   logic signed [CW-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;

   assign s1_in_frame_in = ({22'b0, req_data.pixel_x} < 32'(FRAME_WIDTH)) &&
                           ({22'b0, req_data.pixel_y} < 32'(FRAME_HEIGHT));
   assign s1_dx_in = CW'(signed'({1'b0, req_data.pixel_x})) - ox_s;
   assign s1_dy_in = CW'(signed'({1'b0, req_data.pixel_y})) - oy_s;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_px_ff       <= req_data.pixel_x;
         s1_py_ff       <= req_data.pixel_y;
         s1_dest_ff     <= req_data.dest_pixel;
         s1_in_frame_ff <= s1_in_frame_in;
         s1_dx_ff       <= s1_dx_in;
         s1_dy_ff       <= s1_dy_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: rectangle span tests, squares of the offsets
   // ------------------------------------------------------------------
   logic [31:0]    s2_dest_ff;
   logic           s2_in_frame_ff;
   logic           s2_rect_ff, s2_rect_in;
   logic [DW-1:0]  s2_dx2_ff, s2_dy2_ff;
   logic signed [2*CW-1:0] dx_sq, dy_sq;

   always_comb begin
      logic signed [CW-1:0] px, py;
      logic outer_hit, inner_hit, thick_pos;
      px = CW'(signed'({1'b0, s1_px_ff}));
      py = CW'(signed'({1'b0, s1_py_ff}));
      // an empty span (zero size, or inner size not positive) never hits
      outer_hit = (px >= x_lo_ff) && (px < x_hi_ff) &&
                  (py >= y_lo_ff) && (py < y_hi_ff);
      inner_hit = (px >= xi_lo_ff) && (px < xi_hi_ff) &&
                  (py >= yi_lo_ff) && (py < yi_hi_ff);
      thick_pos = !thick_ff[11] && (thick_ff != 12'sd0);
      if (mode_ff == scab_pkg::MODE_RECT_LINE) begin
         s2_rect_in = outer_hit && thick_pos && !inner_hit;
      end else begin
         s2_rect_in = outer_hit;
      end
   end

   assign dx_sq = s1_dx_ff * s1_dx_ff;
   assign dy_sq = s1_dy_ff * s1_dy_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_dest_ff     <= s1_dest_ff;
         s2_in_frame_ff <= s1_in_frame_ff;
         s2_rect_ff     <= s2_rect_in;
         s2_dx2_ff      <= dx_sq[DW-1:0];
         s2_dy2_ff      <= dy_sq[DW-1:0];
      end
   end

   // ------------------------------------------------------------------
   // stage 3: squared distance
   // ------------------------------------------------------------------
   logic [31:0]   s3_dest_ff;
   logic          s3_in_frame_ff;
   logic          s3_rect_ff;
   logic [DW-1:0] s3_d2_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_dest_ff     <= s2_dest_ff;
         s3_in_frame_ff <= s2_in_frame_ff;
         s3_rect_ff     <= s2_rect_ff;
         s3_d2_ff       <= s2_dx2_ff + s2_dy2_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: circle tests, final coverage, blend products
   // ------------------------------------------------------------------
   logic [31:0] s4_dest_ff;
   logic        s4_cov_ff, s4_cov_in;
   logic [31:0] blend_out;

   always_comb begin
      logic circ_out, circ_in, shape_hit;
      circ_out = (s3_d2_ff <= outer_ff);
      circ_in  = (s3_d2_ff >= inner_ff);
      case (mode_ff)
         scab_pkg::MODE_FILL_RECT:   shape_hit = s3_rect_ff;
         scab_pkg::MODE_RECT_LINE:   shape_hit = s3_rect_ff;
         scab_pkg::MODE_FILL_CIRCLE: shape_hit = circ_out;
         scab_pkg::MODE_CIRCLE_RING: shape_hit = circ_out && circ_in;
         default:                    shape_hit = 1'b0;
      endcase
      s4_cov_in = s3_in_frame_ff && shape_hit;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_dest_ff <= s3_dest_ff;
         s4_cov_ff  <= s4_cov_in;
      end
   end

   scab_blend u_blend (
      .clock     (clock),
      .load_en   (en4),
      .src_color (color_ff),
      .dst_color (s3_dest_ff),
      .blended   (blend_out)
   );

   // ------------------------------------------------------------------
   // stage 5: response register
   // ------------------------------------------------------------------
   scab_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.covered      = s4_cov_ff;
      rsp_in.result_pixel = s4_cov_ff ? blend_out : s4_dest_ff;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // uncovered pixel leaves unchanged
   assert property (@(posedge clock) disable iff (reset)
      (en5 && s4_valid_ff && !s4_cov_ff) |=> (rsp_data.result_pixel == $past(s4_dest_ff)))
      else $error("uncovered pixel was modified");

   // covered pixel under an opaque color takes the color as is
   assert property (@(posedge clock) disable iff (reset)
      (en5 && s4_valid_ff && s4_cov_ff &&
       (color_ff[31:24] == scab_pkg::ALPHA_OPAQUE))
      |=> (rsp_data.result_pixel == $past(color_ff)))
      else $error("opaque blend did not return the draw color");

   // a pixel outside the frame is never covered
   assert property (@(posedge clock) disable iff (reset)
      (en4 && s3_valid_ff && !s3_in_frame_ff) |=> !s4_cov_ff)
      else $error("clipped pixel marked covered");

   // requests are held off only when every stage is full and output stalls
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff &&
                     s5_valid_ff && rsp_stall))
      else $error("request stalled with an empty stage");
`endif

endmodule

### verif/tb_shape_coverage_alpha_blend.sv
// ----------------------------------------------------------------------------
// tb_shape_coverage_alpha_blend: self-checking bench for the shape blender
// Each phase programs a shape and a draw color, then streams pixels that
// are aimed mostly around the shape. A local model of coverage and
// source-over blending predicts every response. Responses are checked in
// order while both sides throttle at random and the receiver stalls for
// long stretches.
// ----------------------------------------------------------------------------
module tb_shape_coverage_alpha_blend;

   localparam int FRAME_W      = 1024;
   localparam int FRAME_H      = 1024;
   localparam int PIPE_DEPTH   = 5;
   localparam int CHAN_MAX     = 255;
   localparam int RAND_PHASES  = 40;
   localparam int PHASE_PIXELS = 50;
   localparam int LONG_HOLD    = 150;
   localparam int MAX_REPORTS  = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   scab_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   scab_pkg::rsp_type rsp_data;
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index = scab_pkg::CSR_SHAPE_MODE;
   logic [31:0]       csr_wdata = '0;

   // shadow copy of the register file, at reset values
   logic [1:0]  cfg_mode  = scab_pkg::MODE_FILL_RECT;
   int          cfg_ox    = 0;
   int          cfg_oy    = 0;
   int          cfg_w     = 0;
   int          cfg_h     = 0;
   int          cfg_rad   = 0;
   int          cfg_thick = 1;
   logic [31:0] cfg_color = '0;

   scab_pkg::req_type pixel_q[$];    // requests waiting to be offered
   scab_pkg::rsp_type shade_q[$];    // predicted responses, oldest first
   int          mismatch_count = 0;
   int          send_idle_pct  = 22;
   int          recv_idle_pct  = 72;
   logic        hold_arm  = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   shape_coverage_alpha_blend #(
      .FRAME_WIDTH (FRAME_W),
      .FRAME_HEIGHT(FRAME_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // source-over blend of the draw color onto one pixel
   function automatic logic [31:0] blend_over(logic [31:0] dst);
      logic [31:0] mix;
      int sa, s, d;
      sa = cfg_color[31:24];
      if (cfg_color[31:24] == scab_pkg::ALPHA_OPAQUE) return cfg_color;
      if (cfg_color[31:24] == scab_pkg::ALPHA_TRANSPARENT) return dst;
      mix = {scab_pkg::ALPHA_OPAQUE, 24'h0};
      for (int c = 0; c < 3; c++) begin
         s = cfg_color[c*8 +: 8];
         d = dst[c*8 +: 8];
         mix[c*8 +: 8] = 8'((s * sa + d * (CHAN_MAX - sa)) / CHAN_MAX);
      end
      return mix;
   endfunction

   // coverage decision and resulting pixel for one request
   function automatic scab_pkg::rsp_type shade_pixel(scab_pkg::req_type p);
      scab_pkg::rsp_type r;
      int px, py, rx, ry, w, h, iw, ih, t;
      longint dx, dy, d2, outer, k, inner;
      logic hit;
      px  = p.pixel_x;
      py  = p.pixel_y;
      hit = 1'b0;
      if (px < FRAME_W && py < FRAME_H) begin
         if (cfg_mode == scab_pkg::MODE_FILL_RECT ||
             cfg_mode == scab_pkg::MODE_RECT_LINE) begin
            rx = cfg_ox;
            ry = cfg_oy;
            w  = cfg_w;
            h  = cfg_h;
            // negative sizes grow toward the origin
            if (w < 0) begin
               rx = rx + w;
               w  = -w;
            end
            if (h < 0) begin
               ry = ry + h;
               h  = -h;
            end
            if (w != 0 && h != 0 && px >= rx && px < rx + w && py >= ry && py < ry + h) begin
               hit = 1'b1;
               if (cfg_mode == scab_pkg::MODE_RECT_LINE) begin
                  t  = cfg_thick;
                  iw = w - 2 * t;
                  ih = h - 2 * t;
                  if (t <= 0)
                     hit = 1'b0;
                  else if (iw > 0 && ih > 0 && px >= rx + t && px < rx + t + iw &&
                           py >= ry + t && py < ry + t + ih)
                     hit = 1'b0;
               end
            end
         end else begin
            dx    = longint'(px) - cfg_ox;
            dy    = longint'(py) - cfg_oy;
            d2    = dx * dx + dy * dy;
            outer = longint'(cfg_rad) * cfg_rad + cfg_rad;
            if (cfg_mode == scab_pkg::MODE_FILL_CIRCLE) begin
               hit = (d2 <= outer);
            end else begin
               k     = longint'(cfg_rad) - cfg_thick;
               inner = k * k + cfg_rad;
               hit   = (d2 >= inner && d2 <= outer);
            end
         end
      end
      r.covered      = hit;
      r.result_pixel = hit ? blend_over(p.dest_pixel) : p.dest_pixel;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch: %s expected %h got %h at %0t", what, want, got, $realtime);
   endtask

   // request driver: offers queued pixels, predicts each one taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            shade_q.push_back(shade_pixel(req_data));
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_data  <= pixel_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks in order, throttles with rsp_stall
   always @(posedge clock) begin
      scab_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (shade_q.size() == 0) begin
               flag_mismatch("response with nothing pending", '0, rsp_data.result_pixel);
            end else begin
               want = shade_q.pop_front();
               if (rsp_data.covered !== want.covered)
                  flag_mismatch("covered", 32'(want.covered), 32'(rsp_data.covered));
               if (rsp_data.result_pixel !== want.result_pixel)
                  flag_mismatch("result_pixel", want.result_pixel, rsp_data.result_pixel);
            end
         end
         // a long hold-off lets the pipeline fill and back up the input
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   // one register write, mirrored into the shadow copy
   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         scab_pkg::CSR_SHAPE_MODE:       cfg_mode  = value[1:0];
         scab_pkg::CSR_ORIGIN_X:         cfg_ox    = int'($signed(value[11:0]));
         scab_pkg::CSR_ORIGIN_Y:         cfg_oy    = int'($signed(value[11:0]));
         scab_pkg::CSR_SIZE_W:           cfg_w     = int'($signed(value[11:0]));
         scab_pkg::CSR_SIZE_H:           cfg_h     = int'($signed(value[11:0]));
         scab_pkg::CSR_CIRCLE_RADIUS:    cfg_rad   = int'(value[10:0]);
         scab_pkg::CSR_STROKE_THICKNESS: cfg_thick = int'($signed(value[11:0]));
         scab_pkg::CSR_DRAW_COLOR:       cfg_color = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_shape(logic [1:0] mode, int ox, int oy, int w, int h, int r, int t,
                             logic [31:0] color);
      write_csr(scab_pkg::CSR_SHAPE_MODE, 32'(mode));
      write_csr(scab_pkg::CSR_ORIGIN_X, ox);
      write_csr(scab_pkg::CSR_ORIGIN_Y, oy);
      write_csr(scab_pkg::CSR_SIZE_W, w);
      write_csr(scab_pkg::CSR_SIZE_H, h);
      write_csr(scab_pkg::CSR_CIRCLE_RADIUS, r);
      write_csr(scab_pkg::CSR_STROKE_THICKNESS, t);
      write_csr(scab_pkg::CSR_DRAW_COLOR, color);
      // derived thresholds are registered and must settle before pixels are sent
      repeat (3) @(negedge clock);
   endtask

   task automatic push_pixel(int x, int y, logic [31:0] dest);
      scab_pkg::req_type p;
      p.pixel_x    = x[9:0];
      p.pixel_y    = y[9:0];
      p.dest_pixel = dest;
      pixel_q.push_back(p);
   endtask

   // wait until every request is taken and every response checked
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || shade_q.size() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(9, 0))
         0:       return -2048;
         1:       return 2047;
         2, 3:    return int'($urandom_range(4095, 0)) - 2048;
         default: return int'($urandom_range(1100, 0)) - 50;
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(9, 0))
         0:       return -2048;
         1:       return 2047;
         2:       return 0;
         3:       return int'($urandom_range(4095, 0)) - 2048;
         default: return int'($urandom_range(400, 0)) - 200;
      endcase
   endfunction

   function automatic int pick_radius();
      case ($urandom_range(9, 0))
         0:       return 0;
         1:       return 2047;
         2:       return int'($urandom_range(2047, 0));
         default: return int'($urandom_range(200, 0));
      endcase
   endfunction

   function automatic int pick_thickness();
      case ($urandom_range(9, 0))
         0:       return -2048;
         1:       return 2047;
         2:       return 0;
         3:       return int'($urandom_range(4095, 0)) - 2048;
         4:       return -int'($urandom_range(5, 1));
         default: return int'($urandom_range(40, 1));
      endcase
   endfunction

   function automatic logic [31:0] pick_color();
      case ($urandom_range(5, 0))
         0:       return {scab_pkg::ALPHA_TRANSPARENT, 24'($urandom())};
         1:       return {scab_pkg::ALPHA_OPAQUE, 24'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   // pixels aimed around the current shape, with some spread over the frame
   task automatic queue_random_pixels(int count);
      int x, y, lo_x, lo_y, span_x, span_y;
      logic [31:0] dest;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3, 0) == 0) begin
            x = $urandom_range(FRAME_W - 1, 0);
            y = $urandom_range(FRAME_H - 1, 0);
         end else if (cfg_mode == scab_pkg::MODE_FILL_RECT ||
                      cfg_mode == scab_pkg::MODE_RECT_LINE) begin
            lo_x   = (cfg_w < 0) ? cfg_ox + cfg_w : cfg_ox;
            lo_y   = (cfg_h < 0) ? cfg_oy + cfg_h : cfg_oy;
            span_x = (cfg_w < 0) ? -cfg_w : cfg_w;
            span_y = (cfg_h < 0) ? -cfg_h : cfg_h;
            x = lo_x - 2 + int'($urandom_range(span_x + 4, 0));
            y = lo_y - 2 + int'($urandom_range(span_y + 4, 0));
         end else begin
            x = cfg_ox - cfg_rad - 2 + int'($urandom_range(2 * cfg_rad + 4, 0));
            y = cfg_oy - cfg_rad - 2 + int'($urandom_range(2 * cfg_rad + 4, 0));
         end
         case ($urandom_range(9, 0))
            0:       dest = '0;
            1:       dest = '1;
            default: dest = $urandom();
         endcase
         push_pixel(x, y, dest);
      end
   endtask

   // main sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // reset defaults: zero-size rectangle covers nothing
      push_pixel(0, 0, 32'h1234_5678);
      wait_idle();

      // filled rectangle across the frame corner, opaque color
      load_shape(scab_pkg::MODE_FILL_RECT, -5, -3, 10, 8, 0, 1, 32'hFF11_2233);
      push_pixel(0, 0, 32'h0000_0000);
      push_pixel(5, 0, 32'h0000_0000);
      push_pixel(4, 4, 32'hFFFF_FFFF);
      push_pixel(1023, 1023, 32'hFFFF_FFFF);
      wait_idle();

      // most negative sizes, half alpha
      load_shape(scab_pkg::MODE_FILL_RECT, 1023, 1023, -2048, -2048, 0, 1, 32'h80C0_4020);
      push_pixel(1022, 1022, 32'hFFFF_FFFF);
      push_pixel(1023, 5, 32'hFFFF_FFFF);
      push_pixel(0, 1022, 32'h0000_0000);
      wait_idle();

      // outline with a hole, transparent color still reports coverage
      load_shape(scab_pkg::MODE_RECT_LINE, 10, 10, 10, 10, 0, 2, 32'h00AB_CDEF);
      push_pixel(10, 10, 32'h5555_AAAA);
      push_pixel(15, 15, 32'h5555_AAAA);
      push_pixel(12, 12, 32'h5555_AAAA);
      push_pixel(11, 15, 32'h5555_AAAA);
      wait_idle();

      // outline with zero thickness draws nothing
      load_shape(scab_pkg::MODE_RECT_LINE, 10, 10, 10, 10, 0, 0, 32'hFF00_00FF);
      push_pixel(10, 10, 32'h0102_0304);
      wait_idle();

      // thickness beyond half the size leaves no hole
      load_shape(scab_pkg::MODE_RECT_LINE, -1000, -1000, 2047, 2047, 0, 2047,
                 32'h7F00_0000);
      push_pixel(1023, 1023, 32'hFFFF_FFFF);
      wait_idle();

      // zero radius disc is the center pixel only
      load_shape(scab_pkg::MODE_FILL_CIRCLE, 5, 5, 0, 0, 0, 1, 32'h01FF_FFFF);
      push_pixel(5, 5, 32'h0000_0000);
      push_pixel(5, 6, 32'h0000_0000);
      wait_idle();

      // ring edges, inside and outside each bound
      load_shape(scab_pkg::MODE_CIRCLE_RING, 0, 0, 0, 0, 10, 3, 32'hFE10_2030);
      push_pixel(8, 0, 32'hFFEE_DDCC);
      push_pixel(7, 0, 32'hFFEE_DDCC);
      push_pixel(10, 0, 32'hFFEE_DDCC);
      push_pixel(11, 0, 32'hFFEE_DDCC);
      wait_idle();

      // negative ring thickness pushes the inner bound past the outer
      load_shape(scab_pkg::MODE_CIRCLE_RING, 0, 0, 0, 0, 2047, -2048, 32'hFFFF_FFFF);
      push_pixel(0, 0, 32'h0000_0000);
      wait_idle();

      // largest disc centered off the frame
      load_shape(scab_pkg::MODE_FILL_CIRCLE, 2047, 2047, 0, 0, 2047, 1, 32'hC0FF_FFFF);
      push_pixel(1023, 1023, 32'h0000_0000);
      wait_idle();

      // random shapes and pixels
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == RAND_PHASES / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 22;
         end else if (ph == 2 * RAND_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_shape(2'($urandom_range(3, 0)), pick_coord(), pick_coord(), pick_size(),
                    pick_size(), pick_radius(), pick_thickness(), pick_color());
         if (ph % 12 == 3)
            hold_arm = ~hold_arm;
         queue_random_pixels(PHASE_PIXELS);
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
